>>> sv/kcb_pkg.sv
// Package for the Keltner channel band block: shared widths, register
// indexes, sequencer types and the accumulator saturation function.
// No dependencies; every other file of the block uses it.
package kcb_pkg;

    // Default parameter values for the top level.
    localparam int unsigned PRICE_WIDTH_DEF   = 32;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    // Accumulator and multiplier operand geometry.
    localparam int unsigned ACC_W   = 48;
    localparam int unsigned DIFF_W  = ACC_W + 2;
    localparam int unsigned LO_W    = 24;
    localparam int unsigned CHUNK_W = DIFF_W - LO_W;
    localparam int unsigned SUM_W   = ACC_W + 5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULTIPLE = 2'd1;

    // Saturation limits of the accumulators at sum width.
    localparam logic signed [SUM_W-1:0] ACC_MAX_S =
        {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN_S = ~ACC_MAX_S;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_TR,
        S_MAX,
        S_LOAD,
        S_MLO,
        S_MHI,
        S_MSUM,
        S_APPLY,
        S_BAND,
        S_OUT
    } t_state;

    // Which product the shared multiplier is working on.
    typedef enum logic [1:0] {
        JOB_PRICE,
        JOB_RANGE,
        JOB_OFFSET
    } t_job;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic sel_hi;
        logic acc_init;
        logic acc_add;
    } t_mac_ctl;

    // Clamp a wide signed sum to the signed accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] res;
        if (v > ACC_MAX_S) begin
            res = ACC_MAX_S[ACC_W-1:0];
        end else if (v < ACC_MIN_S) begin
            res = ACC_MIN_S[ACC_W-1:0];
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/kcb_bar_if.sv
// Input channel of the Keltner channel band block: one price bar per
// transaction. Depends on kcb_pkg for the default price width.
interface kcb_bar_if #(
    parameter int unsigned WIDTH = kcb_pkg::PRICE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] high_price;
    logic signed [WIDTH-1:0] low_price;
    logic signed [WIDTH-1:0] close_price;

    modport source (output valid, output high_price, output low_price,
                    output close_price, input ready);
    modport sink   (input valid, input high_price, input low_price,
                    input close_price, output ready);
endinterface

>>> sv/kcb_band_if.sv
// Output channel of the Keltner channel band block: lower band, middle line
// and upper band per transaction. Depends on kcb_pkg for the default width.
interface kcb_band_if #(
    parameter int unsigned WIDTH = kcb_pkg::PRICE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] lower_band;
    logic signed [WIDTH-1:0] middle_line;
    logic signed [WIDTH-1:0] upper_band;

    modport source (output valid, output lower_band, output middle_line,
                    output upper_band, input ready);
    modport sink   (input valid, input lower_band, input middle_line,
                    input upper_band, output ready);
endinterface

>>> sv/keltner_channel_bands.sv
// Keltner channel bands: exponential averages of close and true range,
// with bands at middle +/- multiple x range average.
// Depends on kcb_pkg, kcb_bar_if, kcb_band_if and kcb_mac.
//
//   channel   direction  transaction payload
//   i_bar     in         high_price, low_price, close_price (signed Q16.16)
//   o_band    out        lower_band, middle_line, upper_band (signed Q16.16)
//   i_cfg_*   in         register write: index and data, no handshake
//
// The first bar seeds both averages and gets only its band offset; each
// later bar also runs the true range steps and both averages. No bar is
// taken before the last result is stored. The single shared multiplier is
// used for the price, range and offset products, five sequencer steps each.
// Ready is high only while the sequencer is idle. A result waits in the
// output register; a stall only holds the sequencer when a second result
// is finished. Reset is synchronous and restores the register defaults.
module keltner_channel_bands #(
    parameter int unsigned PRICE_WIDTH   = kcb_pkg::PRICE_WIDTH_DEF,
    parameter int unsigned FRACTION_BITS = kcb_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kcb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [FRACTION_BITS+1:0]          i_cfg_data,
    kcb_bar_if.sink                           i_bar,
    kcb_band_if.source                        o_band
);
    localparam int unsigned PW     = PRICE_WIDTH;
    localparam int unsigned FB     = FRACTION_BITS;
    localparam int unsigned CW     = FB + 2;
    localparam int unsigned MW     = FB + 1;
    localparam int unsigned ACC_W  = kcb_pkg::ACC_W;
    localparam int unsigned DIFF_W = kcb_pkg::DIFF_W;
    localparam int unsigned SUM_W  = kcb_pkg::SUM_W;
    localparam int unsigned MAC_W  = DIFF_W + CW;
    localparam int unsigned BAND_W = ACC_W + 1;
    localparam int unsigned RND_W  = ACC_W + 2;
    localparam int unsigned GUARD  = ACC_W - PW;

    localparam logic [CW-1:0] WEIGHT_RESET = CW'(((1 << (FB + 2)) + 21) / 42);
    localparam logic [MW-1:0] MULT_RESET   = MW'(1) << (FB - 1);
    localparam logic [CW-1:0] WEIGHT_MAX   = CW'(1) << (FB + 1);
    localparam logic [MW-1:0] MULT_MAX     = MW'(1) << FB;

    localparam logic signed [RND_W-1:0] ROUND_HALF = (RND_W'(1) <<< GUARD) >>> 1;
    localparam logic signed [RND_W-1:0] PRICE_MAX  = (RND_W'(1) <<< (PW - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] PRICE_MIN  = ~PRICE_MAX;

    // Round an accumulator-scale value to price scale and saturate it.
    function automatic logic signed [PW-1:0] to_price(input logic signed [BAND_W-1:0] s);
        logic signed [RND_W-1:0] t;
        logic signed [PW-1:0]    res;
        t = (RND_W'(s) + ROUND_HALF) >>> GUARD;
        if (t > PRICE_MAX) begin
            res = PRICE_MAX[PW-1:0];
        end else if (t < PRICE_MIN) begin
            res = PRICE_MIN[PW-1:0];
        end else begin
            res = t[PW-1:0];
        end
        return res;
    endfunction

    kcb_pkg::t_state   r_state, n_state;
    kcb_pkg::t_job     r_job, n_job;
    kcb_pkg::t_mac_ctl mac_ctl;

    logic [CW-1:0] r_weight;
    logic [MW-1:0] r_multiple;
    logic          r_seeded;
    logic          r_out_valid, n_out_valid;

    logic signed [PW-1:0]     r_high, r_low, r_close, r_prev;
    logic signed [PW+1:0]     r_d, r_a, r_b, r_tr;
    logic signed [ACC_W-1:0]  r_pavg, r_ravg, r_off;
    logic signed [DIFF_W-1:0] r_opd;
    logic        [CW-1:0]     r_coef;
    logic signed [BAND_W-1:0] r_lsum, r_usum;
    logic signed [PW-1:0]     r_lower, r_middle, r_upper;

    logic                     bar_accept;
    logic                     out_free;
    logic signed [PW+1:0]     diff_hl, diff_hp, diff_lp, tr_max;
    logic signed [MAC_W-1:0]  mac_acc;
    logic signed [SUM_W-1:0]  rounded;
    logic [CW-1:0]            weight_eff;
    logic [CW-1:0]            multiple_eff;

    assign bar_accept  = i_bar.valid && i_bar.ready;
    assign i_bar.ready = (r_state == kcb_pkg::S_IDLE);
    assign out_free    = !r_out_valid || o_band.ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= WEIGHT_RESET;
            r_multiple <= MULT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kcb_pkg::REG_EMA_WEIGHT:    r_weight   <= i_cfg_data;
                kcb_pkg::REG_BAND_MULTIPLE: r_multiple <= i_cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // Coefficients limited to two for the weight and one for the multiple.
    assign weight_eff   = (r_weight > WEIGHT_MAX) ? WEIGHT_MAX : r_weight;
    assign multiple_eff = CW'((r_multiple > MULT_MAX) ? MULT_MAX : r_multiple);

    // True range terms, the largest of them, and the rounded product.
    always_comb begin
        diff_hl = (PW+2)'(r_high) - (PW+2)'(r_low);
        diff_hp = (PW+2)'(r_high) - (PW+2)'(r_prev);
        diff_lp = (PW+2)'(r_low) - (PW+2)'(r_prev);
        tr_max  = r_d;
        if (r_a > tr_max) begin
            tr_max = r_a;
        end
        if (r_b > tr_max) begin
            tr_max = r_b;
        end
        rounded = SUM_W'($signed(mac_acc[MAC_W-1:FB]));
    end

    // Shared multiply-accumulate unit.
    kcb_mac #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctl     (mac_ctl),
        .i_operand (r_opd),
        .i_coef    (r_coef),
        .o_acc     (mac_acc)
    );

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcb_pkg::S_IDLE;
            r_job       <= kcb_pkg::JOB_PRICE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state, job selection and multiplier control.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_out_valid = r_out_valid && !o_band.ready;
        mac_ctl     = '0;
        case (r_state)
            kcb_pkg::S_IDLE: begin
                if (bar_accept) begin
                    n_state = r_seeded ? kcb_pkg::S_TR : kcb_pkg::S_SEED;
                end
            end
            kcb_pkg::S_SEED: begin
                n_state = kcb_pkg::S_LOAD;
                n_job   = kcb_pkg::JOB_OFFSET;
            end
            kcb_pkg::S_TR: begin
                n_state = kcb_pkg::S_MAX;
            end
            kcb_pkg::S_MAX: begin
                n_state = kcb_pkg::S_LOAD;
                n_job   = kcb_pkg::JOB_PRICE;
            end
            kcb_pkg::S_LOAD: begin
                n_state = kcb_pkg::S_MLO;
            end
            kcb_pkg::S_MLO: begin
                mac_ctl.mul_en = 1'b1;
                n_state        = kcb_pkg::S_MHI;
            end
            kcb_pkg::S_MHI: begin
                mac_ctl.mul_en   = 1'b1;
                mac_ctl.sel_hi   = 1'b1;
                mac_ctl.acc_init = 1'b1;
                n_state          = kcb_pkg::S_MSUM;
            end
            kcb_pkg::S_MSUM: begin
                mac_ctl.acc_add = 1'b1;
                n_state         = kcb_pkg::S_APPLY;
            end
            kcb_pkg::S_APPLY: begin
                case (r_job)
                    kcb_pkg::JOB_PRICE: begin
                        n_state = kcb_pkg::S_LOAD;
                        n_job   = kcb_pkg::JOB_RANGE;
                    end
                    kcb_pkg::JOB_RANGE: begin
                        n_state = kcb_pkg::S_LOAD;
                        n_job   = kcb_pkg::JOB_OFFSET;
                    end
                    default: begin
                        n_state = kcb_pkg::S_BAND;
                    end
                endcase
            end
            kcb_pkg::S_BAND: begin
                n_state = kcb_pkg::S_OUT;
            end
            kcb_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = kcb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kcb_pkg::S_IDLE;
            end
        endcase
    end

    // Seeded flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else if (r_state == kcb_pkg::S_SEED) begin
            r_seeded <= 1'b1;
        end
    end

    // Datapath registers, loaded step by step under the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            kcb_pkg::S_IDLE: begin
                if (bar_accept) begin
                    r_high  <= i_bar.high_price;
                    r_low   <= i_bar.low_price;
                    r_close <= i_bar.close_price;
                end
            end
            kcb_pkg::S_SEED: begin
                r_pavg <= ACC_W'(r_close) <<< GUARD;
                r_ravg <= kcb_pkg::sat_acc(SUM_W'(diff_hl) <<< GUARD);
                r_prev <= r_close;
            end
            kcb_pkg::S_TR: begin
                r_d <= diff_hl;
                r_a <= diff_hp[PW+1] ? -diff_hp : diff_hp;
                r_b <= diff_lp[PW+1] ? -diff_lp : diff_lp;
            end
            kcb_pkg::S_MAX: begin
                r_tr   <= tr_max;
                r_prev <= r_close;
            end
            kcb_pkg::S_LOAD: begin
                case (r_job)
                    kcb_pkg::JOB_PRICE: begin
                        r_opd  <= (DIFF_W'(r_close) <<< GUARD) - DIFF_W'(r_pavg);
                        r_coef <= weight_eff;
                    end
                    kcb_pkg::JOB_RANGE: begin
                        r_opd  <= (DIFF_W'(r_tr) <<< GUARD) - DIFF_W'(r_ravg);
                        r_coef <= weight_eff;
                    end
                    default: begin
                        r_opd  <= DIFF_W'(r_ravg);
                        r_coef <= multiple_eff;
                    end
                endcase
            end
            kcb_pkg::S_APPLY: begin
                case (r_job)
                    kcb_pkg::JOB_PRICE: begin
                        r_pavg <= kcb_pkg::sat_acc(rounded + SUM_W'(r_pavg));
                    end
                    kcb_pkg::JOB_RANGE: begin
                        r_ravg <= kcb_pkg::sat_acc(rounded + SUM_W'(r_ravg));
                    end
                    default: begin
                        r_off <= rounded[ACC_W-1:0];
                    end
                endcase
            end
            kcb_pkg::S_BAND: begin
                r_lsum <= BAND_W'(r_pavg) - BAND_W'(r_off);
                r_usum <= BAND_W'(r_pavg) + BAND_W'(r_off);
            end
            kcb_pkg::S_OUT: begin
                if (out_free) begin
                    r_lower  <= to_price(r_lsum);
                    r_middle <= to_price(BAND_W'(r_pavg));
                    r_upper  <= to_price(r_usum);
                end
            end
            default: ;
        endcase
    end

    assign o_band.valid       = r_out_valid;
    assign o_band.lower_band  = r_lower;
    assign o_band.middle_line = r_middle;
    assign o_band.upper_band  = r_upper;

    // The block takes no second bar right after accepting one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bar_accept |=> !i_bar.ready)
        else $error("bar accepted while the sequencer was busy");

    // A result appears only from the output step of the sequencer.
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_band.valid) |-> $past(r_state == kcb_pkg::S_OUT))
        else $error("result valid raised outside the output step");

    // Any accepted bar leaves the averages seeded.
    a_seeded_after_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bar_accept |-> ##2 r_seeded)
        else $error("averages not seeded after a bar");

    // The accumulator is never started and added to in the same cycle.
    a_mac_ctl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mac_ctl.acc_init && mac_ctl.acc_add))
        else $error("conflicting multiplier accumulate controls");

endmodule

>>> sv/kcb_mac.sv
// Shared multiply-accumulate unit of the Keltner channel band block.
// Multiplies a 50-bit signed operand by an unsigned coefficient in two
// chunks and forms the product plus a rounding half. Depends on kcb_pkg.
module kcb_mac #(
    parameter int unsigned FRACTION_BITS = kcb_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  kcb_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [kcb_pkg::DIFF_W-1:0]     i_operand,
    input  logic        [FRACTION_BITS+1:0]       i_coef,
    output logic signed [kcb_pkg::DIFF_W+FRACTION_BITS+1:0] o_acc
);
    localparam int unsigned LO_W    = kcb_pkg::LO_W;
    localparam int unsigned CHUNK_W = kcb_pkg::CHUNK_W;
    localparam int unsigned DIFF_W  = kcb_pkg::DIFF_W;
    localparam int unsigned CW      = FRACTION_BITS + 2;
    localparam int unsigned PROD_W  = CHUNK_W + CW + 1;
    localparam int unsigned MAC_W   = DIFF_W + CW;
    localparam logic signed [MAC_W-1:0] HALF = MAC_W'(1) <<< (FRACTION_BITS - 1);

    logic signed [CHUNK_W-1:0] chunk;
    logic signed [PROD_W-1:0]  product;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MAC_W-1:0]   r_acc;

    // Pick the operand chunk: low bits as an unsigned value, high bits signed.
    always_comb begin
        if (i_ctl.sel_hi) begin
            chunk = i_operand[DIFF_W-1:LO_W];
        end else begin
            chunk = $signed(CHUNK_W'(i_operand[LO_W-1:0]));
        end
        product = PROD_W'(chunk) * PROD_W'($signed({1'b0, i_coef}));
    end

    // Product register, then accumulate the low part with the rounding half
    // and the high part shifted into place.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= product;
        end
        if (i_ctl.acc_init) begin
            r_acc <= MAC_W'(r_prod) + HALF;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + (MAC_W'(r_prod) <<< LO_W);
        end
    end

    assign o_acc = r_acc;

endmodule
